[rtl/gris_pkg.sv]
// shared constants, arctangent table and output saturation for the ray setup unit
`default_nettype none

package gris_pkg;

    // fixed field widths
    localparam int TILE_W = 11;
    localparam int POS_W = 24;
    localparam int ANG_W = 16;
    localparam int OUT_W = 32;

    // cordic rotation steps and quotient bits of the dividers
    localparam int CORDIC_STEPS = 30;
    localparam int QUO_BITS = 34;
    localparam int DIV_LAT = QUO_BITS + 1;

    localparam logic [TILE_W-1:0] TILE_RESET = 11'd64;

    // arctangent of 2^-i, full circle equals 2^32
    function automatic logic signed [31:0] atan_unit(input int i);
        logic signed [31:0] v;
        case (i)
            0:  v = 32'sh20000000;
            1:  v = 32'sh12E4051E;
            2:  v = 32'sh09FB385B;
            3:  v = 32'sh051111D4;
            4:  v = 32'sh028B0D43;
            5:  v = 32'sh0145D7E1;
            6:  v = 32'sh00A2F61E;
            7:  v = 32'sh00517C55;
            8:  v = 32'sh0028BE53;
            9:  v = 32'sh00145F2F;
            10: v = 32'sh000A2F98;
            11: v = 32'sh000517CC;
            12: v = 32'sh00028BE6;
            13: v = 32'sh000145F3;
            14: v = 32'sh0000A2FA;
            15: v = 32'sh0000517D;
            16: v = 32'sh000028BE;
            17: v = 32'sh0000145F;
            18: v = 32'sh00000A30;
            19: v = 32'sh00000518;
            20: v = 32'sh0000028C;
            21: v = 32'sh00000146;
            22: v = 32'sh000000A3;
            23: v = 32'sh00000051;
            24: v = 32'sh00000029;
            25: v = 32'sh00000014;
            26: v = 32'sh0000000A;
            27: v = 32'sh00000005;
            28: v = 32'sh00000003;
            29: v = 32'sh00000001;
            default: v = 32'sh0;
        endcase
        return v;
    endfunction

    // clamp a wide signed sum into the signed output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [QUO_BITS+2:0] v);
        logic signed [QUO_BITS+2:0] hi;
        logic signed [QUO_BITS+2:0] lo;
        hi = (QUO_BITS+3)'(32'sh7FFFFFFF);
        lo = (QUO_BITS+3)'(-33'sd2147483648);
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/gris_div.sv]
// pipelined magnitude divider, one quotient bit per stage, saturating quotient
`default_nettype none

module gris_div
    import gris_pkg::*;
#(
    parameter int NUM_W = 52
) (
    input  wire logic                        i_clk,
    input  wire logic [NUM_W-1:0]            i_num,
    input  wire logic [31:0]                 i_den,
    input  wire logic                        i_neg,
    output logic signed [QUO_BITS+1:0]       o_quo
);

    typedef struct packed {
        logic [31:0]          rem;
        logic [QUO_BITS-1:0]  low;
        logic [QUO_BITS-1:0]  quo;
        logic [31:0]          den;
        logic                 neg;
        logic                 sat;
        logic                 zero;
    } t_dv;

    t_dv r_dv [0:QUO_BITS];

    // overflow test: quotient would not fit in the quotient bits
    logic [32+QUO_BITS-1:0] w_num_ext;
    logic                   w_sat;
    assign w_num_ext = (32+QUO_BITS)'(i_num);
    assign w_sat = w_num_ext >= {i_den, {QUO_BITS{1'b0}}};

    // entry stage
    always_ff @(posedge i_clk) begin
        r_dv[0].rem  <= 32'(i_num >> QUO_BITS);
        r_dv[0].low  <= i_num[QUO_BITS-1:0];
        r_dv[0].quo  <= '0;
        r_dv[0].den  <= i_den;
        r_dv[0].neg  <= i_neg;
        r_dv[0].sat  <= w_sat;
        r_dv[0].zero <= (i_num == '0);
    end

    // restoring steps
    for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
        logic [32:0] w_tr;
        logic [32:0] w_diff;
        logic        w_ge;
        assign w_tr = {r_dv[k].rem, r_dv[k].low[QUO_BITS-1]};
        assign w_diff = w_tr - {1'b0, r_dv[k].den};
        assign w_ge = w_tr >= {1'b0, r_dv[k].den};
        always_ff @(posedge i_clk) begin
            r_dv[k+1].rem  <= w_ge ? w_diff[31:0] : w_tr[31:0];
            r_dv[k+1].low  <= {r_dv[k].low[QUO_BITS-2:0], 1'b0};
            r_dv[k+1].quo  <= {r_dv[k].quo[QUO_BITS-2:0], w_ge};
            r_dv[k+1].den  <= r_dv[k].den;
            r_dv[k+1].neg  <= r_dv[k].neg;
            r_dv[k+1].sat  <= r_dv[k].sat;
            r_dv[k+1].zero <= r_dv[k].zero;
        end
    end

    // signed result: zero for a zero numerator, else clamped magnitude on overflow or zero divisor
    logic [QUO_BITS+1:0] w_mag;
    always_comb begin
        if (r_dv[QUO_BITS].zero) begin
            w_mag = '0;
        end else if (r_dv[QUO_BITS].sat) begin
            w_mag = (QUO_BITS+2)'(1) << QUO_BITS;
        end else begin
            w_mag = (QUO_BITS+2)'(r_dv[QUO_BITS].quo);
        end
    end
    assign o_quo = r_dv[QUO_BITS].neg ? -$signed(w_mag) : $signed(w_mag);

endmodule

`default_nettype wire

[rtl/grid_ray_intersection_setup_unit.sv]
// top level: ray grid first crossings and step vectors, fully pipelined
// stages from start to o_done: 1 entry, 30 cordic, 3 setup, 35 divide, 1 out
// throughput: one item per cycle; busy stays low, the pipeline never stalls
// rate set by one cordic step and one quotient bit per register stage
// synchronous active-low reset clears the valid line and sets the grid pitch to 64
// results appear for one cycle on o_done; the receiver cannot hold them off
`default_nettype none

module grid_ray_intersection_setup_unit
    import gris_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [POS_W-1:0]        i_pos_x,
    input  wire logic [POS_W-1:0]        i_pos_y,
    input  wire logic [ANG_W-1:0]        i_ray_angle,
    input  wire logic                    i_facing_left,
    input  wire logic                    i_facing_down,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [TILE_W-1:0]       i_cfg_data,
    output logic                         o_done,
    output logic signed [OUT_W-1:0]      o_vert_hit_x,
    output logic signed [OUT_W-1:0]      o_vert_hit_y,
    output logic signed [OUT_W-1:0]      o_vert_step_x,
    output logic signed [OUT_W-1:0]      o_vert_step_y,
    output logic signed [OUT_W-1:0]      o_horz_hit_x,
    output logic signed [OUT_W-1:0]      o_horz_hit_y,
    output logic signed [OUT_W-1:0]      o_horz_step_x,
    output logic signed [OUT_W-1:0]      o_horz_step_y
);

    localparam int TW = TILE_W + FRAC_BITS;
    localparam int NW = TW + 1;
    localparam int PW = NW + 32;
    localparam int MW = PW - 1;
    localparam int AW = POS_W - FRAC_BITS;
    localparam int SW = QUO_BITS + 3;
    localparam int LAT = 1 + CORDIC_STEPS + 3 + DIV_LAT + 1;

    typedef struct packed {
        logic [31:0]        c;
        logic [31:0]        s;
        logic [31:0]        z;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic               left;
        logic               down;
        logic [TILE_W-1:0]  rx;
        logic [TILE_W-1:0]  ry;
    } t_cd;

    typedef struct packed {
        logic [31:0]        vx;
        logic [31:0]        hy;
        logic [NW-1:0]      nv;
        logic [NW-1:0]      nh;
        logic [TW-1:0]      t;
        logic [31:0]        c;
        logic [31:0]        s;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic               left;
        logic               down;
    } t_m1;

    typedef struct packed {
        logic [PW-1:0]      pv;
        logic [PW-1:0]      pvs;
        logic [PW-1:0]      ph;
        logic [PW-1:0]      phs;
        logic [31:0]        c;
        logic [31:0]        s;
    } t_m2;

    typedef struct packed {
        logic [MW-1:0]      av;
        logic [MW-1:0]      avs;
        logic [MW-1:0]      ah;
        logic [MW-1:0]      ahs;
        logic [31:0]        ac;
        logic [31:0]        as_;
        logic               nv;
        logic               nh;
    } t_m3;

    typedef struct packed {
        logic [31:0]        vx;
        logic [31:0]        hy;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic               left;
        logic               down;
        logic [TW-1:0]      t;
    } t_sd;

    logic [TILE_W-1:0] r_grid_pitch;
    logic [LAT-1:0]    r_vld;
    t_cd               r_cd [0:CORDIC_STEPS];
    t_m1               r_m1;
    t_m2               r_m2;
    t_m3               r_m3;
    t_sd               r_sd [0:DIV_LAT-1];
    t_sd               r_sd_m2;
    t_sd               r_sd_m3;

    logic w_accept;
    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept = start && !busy;

    // tile size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_pitch <= TILE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_grid_pitch <= i_cfg_data;
        end
    end

    logic [TILE_W-1:0] w_ts;
    assign w_ts = (r_grid_pitch == '0) ? TILE_W'(1) : r_grid_pitch;

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    // entry: angle to 32-bit turn, folded into a half turn
    logic [31:0] w_a32;
    assign w_a32 = {16'b0, i_ray_angle} << (32 - ANGLE_BITS);

    always_ff @(posedge i_clk) begin
        r_cd[0].c    <= 32'h20000000;
        r_cd[0].s    <= '0;
        r_cd[0].z    <= {w_a32[30], w_a32[30:0]};
        r_cd[0].px   <= i_pos_x;
        r_cd[0].py   <= i_pos_y;
        r_cd[0].left <= i_facing_left;
        r_cd[0].down <= i_facing_down;
        r_cd[0].rx   <= '0;
        r_cd[0].ry   <= '0;
    end

    // cordic rotation, with the tile remainder division riding alongside
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [31:0] w_dc;
        logic signed [31:0] w_ds;
        logic [TILE_W-1:0]  w_rx;
        logic [TILE_W-1:0]  w_ry;
        assign w_dc = $signed(r_cd[i].s) >>> i;
        assign w_ds = $signed(r_cd[i].c) >>> i;

        if (i < AW) begin : g_rem
            logic [TILE_W:0] w_tx;
            logic [TILE_W:0] w_ty;
            assign w_tx = {r_cd[i].rx, r_cd[i].px[POS_W-1-i]};
            assign w_ty = {r_cd[i].ry, r_cd[i].py[POS_W-1-i]};
            assign w_rx = (w_tx >= {1'b0, w_ts}) ? TILE_W'(w_tx - {1'b0, w_ts})
                                                 : TILE_W'(w_tx);
            assign w_ry = (w_ty >= {1'b0, w_ts}) ? TILE_W'(w_ty - {1'b0, w_ts})
                                                 : TILE_W'(w_ty);
        end else begin : g_hold
            assign w_rx = r_cd[i].rx;
            assign w_ry = r_cd[i].ry;
        end

        always_ff @(posedge i_clk) begin
            if (!r_cd[i].z[31]) begin
                r_cd[i+1].c <= $signed(r_cd[i].c) - w_dc;
                r_cd[i+1].s <= $signed(r_cd[i].s) + w_ds;
                r_cd[i+1].z <= $signed(r_cd[i].z) - atan_unit(i);
            end else begin
                r_cd[i+1].c <= $signed(r_cd[i].c) + w_dc;
                r_cd[i+1].s <= $signed(r_cd[i].s) - w_ds;
                r_cd[i+1].z <= $signed(r_cd[i].z) + atan_unit(i);
            end
            r_cd[i+1].px   <= r_cd[i].px;
            r_cd[i+1].py   <= r_cd[i].py;
            r_cd[i+1].left <= r_cd[i].left;
            r_cd[i+1].down <= r_cd[i].down;
            r_cd[i+1].rx   <= w_rx;
            r_cd[i+1].ry   <= w_ry;
        end
    end

    // first grid lines and distances to them
    t_cd         w_ce;
    logic [TW-1:0] w_t;
    logic [31:0] w_px32;
    logic [31:0] w_py32;
    logic [31:0] w_vbase;
    logic [31:0] w_hbase;
    logic [31:0] w_vx;
    logic [31:0] w_hy;
    logic [31:0] w_fmask;
    assign w_ce = r_cd[CORDIC_STEPS];
    assign w_t = {w_ts, {FRAC_BITS{1'b0}}};
    assign w_fmask = (32'(1) << FRAC_BITS) - 32'(1);
    assign w_px32 = 32'(w_ce.px);
    assign w_py32 = 32'(w_ce.py);
    assign w_vbase = w_px32 - (w_px32 & w_fmask) - (32'(w_ce.rx) << FRAC_BITS);
    assign w_hbase = w_py32 - (w_py32 & w_fmask) - (32'(w_ce.ry) << FRAC_BITS);
    assign w_vx = w_ce.left ? w_vbase : w_vbase + 32'(w_t);
    assign w_hy = w_ce.down ? w_hbase + 32'(w_t) : w_hbase;

    always_ff @(posedge i_clk) begin
        r_m1.vx   <= w_vx;
        r_m1.hy   <= w_hy;
        r_m1.nv   <= NW'(w_vx - w_px32);
        r_m1.nh   <= NW'(w_hy - w_py32);
        r_m1.t    <= w_t;
        r_m1.c    <= w_ce.c;
        r_m1.s    <= w_ce.s;
        r_m1.px   <= w_ce.px;
        r_m1.py   <= w_ce.py;
        r_m1.left <= w_ce.left;
        r_m1.down <= w_ce.down;
    end

    // products of distances and tile size with sine and cosine
    logic signed [PW-1:0] w_pv;
    logic signed [PW-1:0] w_pvs;
    logic signed [PW-1:0] w_ph;
    logic signed [PW-1:0] w_phs;
    assign w_pv  = $signed(r_m1.nv) * $signed(r_m1.s);
    assign w_pvs = $signed({1'b0, r_m1.t}) * $signed(r_m1.s);
    assign w_ph  = $signed(r_m1.nh) * $signed(r_m1.c);
    assign w_phs = $signed({1'b0, r_m1.t}) * $signed(r_m1.c);

    always_ff @(posedge i_clk) begin
        r_m2.pv  <= w_pv;
        r_m2.pvs <= w_pvs;
        r_m2.ph  <= w_ph;
        r_m2.phs <= w_phs;
        r_m2.c   <= r_m1.c;
        r_m2.s   <= r_m1.s;
        r_sd_m2.vx   <= r_m1.vx;
        r_sd_m2.hy   <= r_m1.hy;
        r_sd_m2.px   <= r_m1.px;
        r_sd_m2.py   <= r_m1.py;
        r_sd_m2.left <= r_m1.left;
        r_sd_m2.down <= r_m1.down;
        r_sd_m2.t    <= r_m1.t;
    end

    // magnitudes and quotient signs
    function automatic logic [MW-1:0] mag_p(input logic [PW-1:0] p);
        return p[PW-1] ? MW'(-$signed(p)) : MW'(p);
    endfunction

    always_ff @(posedge i_clk) begin
        r_m3.av  <= mag_p(r_m2.pv);
        r_m3.avs <= mag_p(r_m2.pvs);
        r_m3.ah  <= mag_p(r_m2.ph);
        r_m3.ahs <= mag_p(r_m2.phs);
        r_m3.ac  <= r_m2.c[31] ? 32'(-$signed(r_m2.c)) : r_m2.c;
        r_m3.as_ <= r_m2.s[31] ? 32'(-$signed(r_m2.s)) : r_m2.s;
        r_m3.nv  <= r_m2.pv[PW-1] ^ r_m2.c[31];
        r_m3.nh  <= r_m2.ph[PW-1] ^ r_m2.s[31];
        r_sd_m3  <= r_sd_m2;
    end

    // four dividers and the matching side line
    logic signed [QUO_BITS+1:0] w_q_vy;
    logic signed [QUO_BITS+1:0] w_q_vs;
    logic signed [QUO_BITS+1:0] w_q_hx;
    logic signed [QUO_BITS+1:0] w_q_hs;

    gris_div #(.NUM_W(MW)) u_div_vy (
        .i_clk(i_clk), .i_num(r_m3.av), .i_den(r_m3.ac), .i_neg(r_m3.nv), .o_quo(w_q_vy)
    );
    gris_div #(.NUM_W(MW)) u_div_vs (
        .i_clk(i_clk), .i_num(r_m3.avs), .i_den(r_m3.ac), .i_neg(1'b0), .o_quo(w_q_vs)
    );
    gris_div #(.NUM_W(MW)) u_div_hx (
        .i_clk(i_clk), .i_num(r_m3.ah), .i_den(r_m3.as_), .i_neg(r_m3.nh), .o_quo(w_q_hx)
    );
    gris_div #(.NUM_W(MW)) u_div_hs (
        .i_clk(i_clk), .i_num(r_m3.ahs), .i_den(r_m3.as_), .i_neg(1'b0), .o_quo(w_q_hs)
    );

    always_ff @(posedge i_clk) begin
        r_sd[0] <= r_sd_m3;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    // final sums, signs and saturation
    t_sd                  w_sd;
    logic signed [SW-1:0] w_vy_sum;
    logic signed [SW-1:0] w_hx_sum;
    logic signed [SW-1:0] w_vs;
    logic signed [SW-1:0] w_hs;
    logic signed [31:0]   w_t32;
    assign w_sd = r_sd[DIV_LAT-1];
    assign w_vy_sum = $signed(SW'(w_sd.py)) + SW'(w_q_vy);
    assign w_hx_sum = $signed(SW'(w_sd.px)) + SW'(w_q_hx);
    assign w_vs = w_sd.down ? SW'(w_q_vs) : -SW'(w_q_vs);
    assign w_hs = w_sd.left ? -SW'(w_q_hs) : SW'(w_q_hs);
    assign w_t32 = $signed(32'(w_sd.t));

    always_ff @(posedge i_clk) begin
        o_vert_hit_x  <= $signed(w_sd.vx);
        o_vert_hit_y  <= sat_out(w_vy_sum);
        o_vert_step_x <= w_sd.left ? -w_t32 : w_t32;
        o_vert_step_y <= sat_out(w_vs);
        o_horz_hit_x  <= sat_out(w_hx_sum);
        o_horz_hit_y  <= $signed(w_sd.hy);
        o_horz_step_x <= sat_out(w_hs);
        o_horz_step_y <= w_sd.down ? w_t32 : -w_t32;
    end

    assign o_done = r_vld[LAT-1];

    // each accepted item gives exactly one result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##(LAT) o_done)
        else $error("result missing after pipeline latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, LAT))
        else $error("result without a matching item");

    // both step vectors carry the same tile size
    a_tile_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_vert_step_x == o_horz_step_y) || (o_vert_step_x == -o_horz_step_y))
        else $error("vertical and horizontal tile steps disagree");

    // first cycle out of reset sees the reset tile size
    a_cfg_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (r_grid_pitch == TILE_RESET))
        else $error("tile size not restored by reset");

endmodule

`default_nettype wire
